/* src/mvma_pkg.sv */
// ============================================================================
// mvma_pkg: shared types and constants for the matrix-vector MAC block
// Holds register codes, reset values, queue sizes and the result word layout.
// ============================================================================
package mvma_pkg;

    // Default sizes
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MID_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF   = 8;

    // Configuration port address width (two registers at 0 and 4)
    localparam int PADDR_W = 3;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_ELEMENT_WIDTH = 1'b0;
    localparam logic REG_COLUMN_COUNT  = 1'b1;

    // Register reset values
    localparam logic [1:0] ELEMENT_WIDTH_RST = 2'd2;
    localparam logic [6:0] COLUMN_COUNT_RST  = 7'd64;

    // Matrix element width modes; the unused code acts as 32-bit
    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2
    } elem_width_t;

    // Input word commands
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_MATRIX = 1'b1
    } command_t;

    // One finished row as it waits in the result queue
    typedef struct packed {
        logic [63:0] row_sum;
        logic [15:0] row_number;
        logic        last_row;
    } result_t;

    // Width of one front-to-back queue word for a given store address width
    function automatic int entry_width(int aw);
        return 1 + 1 + aw + 64 + 32 + 1 + 1 + 16;
    endfunction

endpackage

/* src/mvma_cfg.sv */
// ============================================================================
// mvma_cfg: configuration registers
// APB-style register file holding the element width mode and column count.
// ============================================================================
module mvma_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvma_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [1:0]                  element_width,
    output logic [6:0]                  column_count
);

    logic [1:0] width_reg;
    logic [6:0] count_reg;
    logic       wr_fire;

    // Write completes in the access phase
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= mvma_pkg::ELEMENT_WIDTH_RST;
            count_reg <= mvma_pkg::COLUMN_COUNT_RST;
        end
        else if (wr_fire)
        begin
            if (paddr[2] == mvma_pkg::REG_COLUMN_COUNT)
            begin
                count_reg <= pwdata[6:0];
            end
            else
            begin
                width_reg <= pwdata[1:0];
            end
        end
    end

    // Read back the addressed register
    always_comb
    begin
        if (paddr[2] == mvma_pkg::REG_COLUMN_COUNT)
        begin
            prdata = {25'd0, count_reg};
        end
        else
        begin
            prdata = {30'd0, width_reg};
        end
    end

    assign element_width = width_reg;
    assign column_count  = count_reg;

endmodule

/* src/mvma_fifo.sv */
// ============================================================================
// mvma_fifo: small register queue
// Flip-flop FIFO with registered count; full and empty come from the count.
// ============================================================================
module mvma_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       full,
    output logic                       empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    head_reg;
    logic [PW-1:0]    tail_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    // Advance the pointers and the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                tail_reg <= (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (do_rd)
            begin
                head_reg <= (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[tail_reg] <= wr_data;
        end
    end

    assign rd_data = slot_reg[head_reg];
    assign count   = count_reg;

endmodule

/* src/mvma_front.sv */
// ============================================================================
// mvma_front: input word classifier
// Accepts input words, tracks column and row position, narrows matrix
// elements and queues one command word per item for the back end.
// ============================================================================
module mvma_front #(
    parameter int MAX_COLUMNS = mvma_pkg::MAX_COLUMNS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   command,
    input  logic [5:0]                             vector_index,
    input  logic signed [63:0]                     vector_value,
    input  logic signed [31:0]                     matrix_element,
    input  logic                                   end_of_matrix,
    input  logic [1:0]                             element_width,
    input  logic [6:0]                             column_count,
    input  logic                                   q_full,
    output logic                                   q_wr_en,
    output logic [mvma_pkg::entry_width($clog2(MAX_COLUMNS))-1:0] q_wr_data
);

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    typedef struct packed {
        logic               is_matrix;
        logic               store_wr;
        logic [AW-1:0]      addr;
        logic [63:0]        value;
        logic signed [31:0] elem;
        logic               row_end;
        logic               end_mark;
        logic [15:0]        row_number;
    } entry_t;

    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [15:0]   row_reg;
    logic [15:0]   row_next;
    logic          accept;
    logic          is_matrix;
    logic          row_end;
    logic [EW-1:0] count_ext;
    logic [EW-1:0] eff_count;
    logic [EW-1:0] pos_plus;
    logic signed [31:0] elem_ext;
    entry_t        entry;

    assign accept    = push && !q_full;
    assign is_matrix = (command == mvma_pkg::CMD_MATRIX);

    // Clamp the column count to 1 .. MAX_COLUMNS
    always_comb
    begin
        count_ext = EW'(column_count);
        if (count_ext == '0)
        begin
            eff_count = EW'(1);
        end
        else if (count_ext > EW'(MAX_COLUMNS))
        begin
            eff_count = EW'(MAX_COLUMNS);
        end
        else
        begin
            eff_count = count_ext;
        end
    end

    assign pos_plus = EW'(pos_reg) + 1'b1;
    assign row_end  = end_of_matrix || (pos_plus >= eff_count);

    // Narrow and sign-extend the matrix element
    always_comb
    begin
        case (element_width)
            mvma_pkg::WIDTH_8:  elem_ext = {{24{matrix_element[7]}}, matrix_element[7:0]};
            mvma_pkg::WIDTH_16: elem_ext = {{16{matrix_element[15]}}, matrix_element[15:0]};
            default:            elem_ext = matrix_element;
        endcase
    end

    // Step the column and row position on matrix words
    always_comb
    begin
        pos_next = pos_reg;
        row_next = row_reg;
        if (accept && is_matrix)
        begin
            if (row_end)
            begin
                pos_next = '0;
                row_next = end_of_matrix ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                pos_next = AW'(pos_plus);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
        end
    end

    // Build the queue word; loads beyond the store are dropped
    always_comb
    begin
        entry.is_matrix  = is_matrix;
        entry.store_wr   = !is_matrix && (int'(vector_index) < MAX_COLUMNS);
        entry.addr       = is_matrix ? pos_reg : AW'(vector_index);
        entry.value      = vector_value;
        entry.elem       = elem_ext;
        entry.row_end    = row_end;
        entry.end_mark   = end_of_matrix;
        entry.row_number = row_reg;
    end

    assign q_wr_en   = accept;
    assign q_wr_data = entry;

endmodule

/* src/mvma_back.sv */
// ============================================================================
// mvma_back: vector store and multiply-accumulate pipeline
// Pops command words, writes or reads the vector store, multiplies in two
// 32-bit halves, accumulates and writes finished rows to the result queue.
// ============================================================================
module mvma_back #(
    parameter int MAX_COLUMNS = mvma_pkg::MAX_COLUMNS_DEF,
    parameter int OUT_DEPTH   = mvma_pkg::OUT_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_empty,
    input  logic [mvma_pkg::entry_width($clog2(MAX_COLUMNS))-1:0] q_rd_data,
    output logic                                   q_rd_en,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]         out_count,
    output logic                                   out_wr_en,
    output mvma_pkg::result_t                      out_wr_data
);

    localparam int AW = $clog2(MAX_COLUMNS);

    typedef struct packed {
        logic               is_matrix;
        logic               store_wr;
        logic [AW-1:0]      addr;
        logic [63:0]        value;
        logic signed [31:0] elem;
        logic               row_end;
        logic               end_mark;
        logic [15:0]        row_number;
    } entry_t;

    // Row bookkeeping that travels with each matrix word
    typedef struct packed {
        logic        valid;
        logic        row_end;
        logic        end_mark;
        logic [15:0] row_number;
    } tag_t;

    entry_t             entry;
    logic               pop;
    logic [1:0]         pending;
    logic [63:0]        store_mem [MAX_COLUMNS];
    tag_t               tag1_reg;
    tag_t               tag2_reg;
    tag_t               tag3_reg;
    logic [63:0]        vec_reg;
    logic signed [31:0] elem_reg;
    logic signed [32:0] vec_lo;
    logic signed [64:0] lo_full;
    logic [31:0]        hi_prod;
    logic [63:0]        lo_reg;
    logic [31:0]        hi_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        acc_next;
    logic [63:0]        sum;

    assign entry = q_rd_data;

    // Pop only with room in the result queue for every row still in flight
    assign pending = 2'(tag1_reg.valid && tag1_reg.row_end)
                   + 2'(tag2_reg.valid && tag2_reg.row_end)
                   + 2'(tag3_reg.valid && tag3_reg.row_end);
    assign pop     = !q_empty && ((int'(out_count) + int'(pending)) < OUT_DEPTH);
    assign q_rd_en = pop;

    // Write a load into the store, read the column entry for a matrix word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (entry.store_wr)
            begin
                store_mem[entry.addr] <= entry.value;
            end
            vec_reg  <= store_mem[entry.addr];
            elem_reg <= entry.elem;
        end
    end

    // Split the 64-bit product into a signed low half and a wrapping high half
    assign vec_lo  = $signed({1'b0, vec_reg[31:0]});
    assign lo_full = vec_lo * elem_reg;
    assign hi_prod = vec_reg[63:32] * $unsigned(elem_reg);

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_full[63:0];
        hi_reg   <= hi_prod;
        prod_reg <= lo_reg + {hi_reg, 32'd0};
    end

    // Advance the row tags alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg.valid      <= pop && entry.is_matrix;
            tag1_reg.row_end    <= entry.row_end;
            tag1_reg.end_mark   <= entry.end_mark;
            tag1_reg.row_number <= entry.row_number;
            tag2_reg            <= tag1_reg;
            tag3_reg            <= tag2_reg;
        end
    end

    // Accumulate; emit and clear at a row end
    assign sum = acc_reg + prod_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (tag3_reg.valid)
        begin
            acc_next = tag3_reg.row_end ? 64'd0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_wr_en              = tag3_reg.valid && tag3_reg.row_end;
    assign out_wr_data.row_sum    = sum;
    assign out_wr_data.row_number = tag3_reg.row_number;
    assign out_wr_data.last_row   = tag3_reg.end_mark;

endmodule

/* src/matrix_vector_multiply_accumulate.sv */
// ============================================================================
// matrix_vector_multiply_accumulate: streaming matrix-vector MAC
// Loads a signed 64-bit vector, then multiplies streamed matrix rows by it.
// ============================================================================
// Input words enter through push/full; a word with command low loads one
// vector entry, a word with command high brings one matrix element in
// row-major order. Row results leave through empty/pop: row_sum, row_number
// and last_row are valid while empty is low and advance on pop.
// Throughput is one input word per cycle while full is low, loads and
// matrix elements alike. After the edge that accepted the last element of
// a row, its result passes through the command queue, the vector store
// read, the split 32-bit multiplies and the merge of the partial products;
// the accumulator add then writes the result queue directly.
// When the receiver stops popping, finished rows collect in the result
// queue; the back end stops draining the command queue once the result
// queue and the rows in flight would fill it, and full rises when the
// command queue is full. Reset empties both queues, clears accumulator,
// column and row position, and restores element_width to 32-bit and
// column_count to 64. The vector store is not cleared; load each entry
// before a matrix row uses it.
// ============================================================================
module matrix_vector_multiply_accumulate #(
    parameter int MAX_COLUMNS = mvma_pkg::MAX_COLUMNS_DEF,
    parameter int MID_DEPTH   = mvma_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH   = mvma_pkg::OUT_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         command,
    input  logic [5:0]                   vector_index,
    input  logic signed [63:0]           vector_value,
    input  logic signed [31:0]           matrix_element,
    input  logic                         end_of_matrix,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [63:0]           row_sum,
    output logic [15:0]                  row_number,
    output logic                         last_row,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mvma_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int AW      = $clog2(MAX_COLUMNS);
    localparam int ENTRY_W = mvma_pkg::entry_width(AW);
    localparam int RES_W   = $bits(mvma_pkg::result_t);
    localparam int OCW     = $clog2(OUT_DEPTH + 1);

    logic [1:0]          element_width;
    logic [6:0]          column_count;
    logic                mid_wr_en;
    logic [ENTRY_W-1:0]  mid_wr_data;
    logic                mid_rd_en;
    logic [ENTRY_W-1:0]  mid_rd_data;
    logic                mid_full;
    logic                mid_empty;
    logic                out_wr_en;
    mvma_pkg::result_t   out_wr_data;
    mvma_pkg::result_t   out_rd_data;
    logic [OCW-1:0]      out_count;

    mvma_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .element_width (element_width),
        .column_count  (column_count)
    );

    mvma_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .command        (command),
        .vector_index   (vector_index),
        .vector_value   (vector_value),
        .matrix_element (matrix_element),
        .end_of_matrix  (end_of_matrix),
        .element_width  (element_width),
        .column_count   (column_count),
        .q_full         (mid_full),
        .q_wr_en        (mid_wr_en),
        .q_wr_data      (mid_wr_data)
    );

    mvma_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr_en),
        .wr_data (mid_wr_data),
        .rd_en   (mid_rd_en),
        .rd_data (mid_rd_data),
        .count   (),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    mvma_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (mid_empty),
        .q_rd_data   (mid_rd_data),
        .q_rd_en     (mid_rd_en),
        .out_count   (out_count),
        .out_wr_en   (out_wr_en),
        .out_wr_data (out_wr_data)
    );

    mvma_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RES_W)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr_en),
        .wr_data (out_wr_data),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .count   (out_count),
        .full    (),
        .empty   (empty)
    );

    assign full       = mid_full;
    assign row_sum    = $signed(out_rd_data.row_sum);
    assign row_number = out_rd_data.row_number;
    assign last_row   = out_rd_data.last_row;

endmodule

/* src/mvma_checker.sv */
// ============================================================================
// mvma_checker: port-level checks for the matrix-vector MAC
// Watches reset behavior, the result queue and the row numbering sequence.
// ============================================================================
module mvma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] row_sum,
    input logic [15:0] row_number,
    input logic        last_row,
    input logic        pready
);

    logic        prev_last_reg;
    logic [15:0] prev_row_reg;
    logic        deliver;

    assign deliver = pop && !empty;

    // Remember the last delivered row; the first row after reset counts as
    // following an end of matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_last_reg <= 1'b1;
            prev_row_reg  <= '0;
        end
        else if (deliver)
        begin
            prev_last_reg <= last_row;
            prev_row_reg  <= row_number;
        end
    end

    // Both queues come out of reset empty
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> empty && !full)
        else $error("queues not empty after reset");

    // The register port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(row_sum) && $stable(row_number)
                           && $stable(last_row))
        else $error("waiting result changed");

    // Rows number up by one, and restart at zero after a last row
    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        deliver |-> (prev_last_reg ? (row_number == 16'd0)
                                   : (row_number == prev_row_reg + 16'd1)))
        else $error("row number out of sequence");

endmodule

bind matrix_vector_multiply_accumulate mvma_checker u_mvma_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .row_sum    (row_sum),
    .row_number (row_number),
    .last_row   (last_row),
    .pready     (pready)
);
